@@ sv/bmm_pkg.sv @@
`timescale 1ns / 1ps
package bmm_pkg;
  localparam int LEFT_MAX   = 16;
  localparam int RIGHT_MAX  = 16;
  localparam int MAX_DEGREE = 8;
  localparam int VW   = 4;                 // vertex index width
  localparam int KW   = 3;                 // list slot width
  localparam int AW   = VW + KW;           // adjacency address width
  localparam int CW   = 5;                 // count width
  localparam int ADJ_DEPTH = LEFT_MAX * MAX_DEGREE;

  localparam logic [0:0] REG_LEFT_COUNT  = 1'b0;
  localparam logic [0:0] REG_RIGHT_COUNT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ROUND, ST_NEXT, ST_TF_RD, ST_TF_CHK, ST_DFS, ST_DFS_CHK,
    ST_AUG_RD, ST_AUG_WR, ST_EMIT, ST_CLEAR
  } state_t;

  function automatic logic [CW-1:0] clamp_count(input logic [CW-1:0] v,
                                                input logic [CW-1:0] maxv);
    logic [CW-1:0] r;
    if (v == '0) r = CW'(1);
    else if (v > maxv) r = maxv;
    else r = v;
    return r;
  endfunction
endpackage

@@ sv/bmm_ram.sv @@
`timescale 1ns / 1ps
module bmm_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

@@ sv/bipartite_max_matching.sv @@
`timescale 1ns / 1ps
// edge load: one beat per cycle while idle, written straight into the adjacency ram
// solve: after the last beat, kuhn rounds run over the ram, each list slot
//   taking a ram read then a check; length depends on the graph
// results: one beat per left vertex, then the store is cleared
// reset: synchronous, sets vertex counts to 16, clears degrees, partner flags, marks and flags; ram contents undefined
module bipartite_max_matching (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [4:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] left_vertex,
  input  logic [3:0] right_vertex,
  input  logic       has_edge,
  input  logic       last_edge,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] vertex_index,
  output logic       is_matched,
  output logic [3:0] partner,
  output logic [4:0] match_count,
  output logic       dropped_edges,
  output logic       last_result
);
  localparam int VW = bmm_pkg::VW;
  localparam int CW = bmm_pkg::CW;

  bmm_pkg::state_t state, state_next;

  logic [CW-1:0] left_count, right_count;
  logic [VW:0]   deg [bmm_pkg::LEFT_MAX];
  logic [VW-1:0] lp [bmm_pkg::LEFT_MAX];
  logic          lp_ok [bmm_pkg::LEFT_MAX];
  logic [VW-1:0] rp [bmm_pkg::RIGHT_MAX];
  logic          rp_ok [bmm_pkg::RIGHT_MAX];
  logic          visited [bmm_pkg::LEFT_MAX];
  logic [VW-1:0] sv [bmm_pkg::LEFT_MAX];    // search stack: vertex
  logic [VW:0]   sp [bmm_pkg::LEFT_MAX];    // search stack: list position
  logic [VW-1:0] depth;
  logic [VW:0]   d;                          // augment unwind counter
  logic [CW-1:0] i, j, cnt, running;
  logic          drop;
  logic [VW-1:0] tf_v;
  logic [VW:0]   tf_k;
  logic          tf_ret;                     // 0: root try, 1: inside dfs

  logic [CW-1:0] n, m;
  logic          in_acc, edge_bad, emit_go;
  logic [VW-1:0] cur_v, dm1, u, w;
  logic [VW:0]   cur_p;
  logic          ram_we;
  logic [bmm_pkg::AW-1:0] ram_addr;

  assign n = bmm_pkg::clamp_count(left_count, CW'(bmm_pkg::LEFT_MAX));
  assign m = bmm_pkg::clamp_count(right_count, CW'(bmm_pkg::RIGHT_MAX));
  assign in_stall = (state != bmm_pkg::ST_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign edge_bad = ({1'b0, left_vertex} >= n) || ({1'b0, right_vertex} >= m) ||
                    (deg[left_vertex] >= (VW+1)'(bmm_pkg::MAX_DEGREE));
  assign cur_v = sv[depth];
  assign cur_p = sp[depth];
  assign dm1 = VW'(d - 1'b1);
  assign w = rp[u];
  assign emit_go = !out_valid || !out_stall;
  assign ram_we = in_acc && has_edge && !edge_bad;

  always_comb begin
    case (state)
      bmm_pkg::ST_TF_RD:  ram_addr = {tf_v, tf_k[bmm_pkg::KW-1:0]};
      bmm_pkg::ST_DFS:    ram_addr = {cur_v, cur_p[bmm_pkg::KW-1:0]};
      bmm_pkg::ST_AUG_RD: ram_addr = {sv[dm1], sp[dm1][bmm_pkg::KW-1:0]};
      default:            ram_addr = {left_vertex, deg[left_vertex][bmm_pkg::KW-1:0]};
    endcase
  end

  bmm_ram #(.DEPTH(bmm_pkg::ADJ_DEPTH), .WIDTH(VW)) u_adj (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(right_vertex), .rdata(u)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bmm_pkg::ST_IDLE:   if (in_acc && last_edge) state_next = bmm_pkg::ST_ROUND;
      bmm_pkg::ST_ROUND:  state_next = bmm_pkg::ST_NEXT;
      bmm_pkg::ST_NEXT: begin
        if (i >= n) state_next = (cnt != '0) ? bmm_pkg::ST_ROUND : bmm_pkg::ST_EMIT;
        else if (!lp_ok[i[VW-1:0]]) state_next = bmm_pkg::ST_TF_RD;
      end
      bmm_pkg::ST_TF_RD: begin
        if (tf_k >= deg[tf_v]) state_next = bmm_pkg::ST_DFS;
        else state_next = bmm_pkg::ST_TF_CHK;
      end
      bmm_pkg::ST_TF_CHK: begin
        if (!rp_ok[u]) state_next = tf_ret ? bmm_pkg::ST_AUG_RD : bmm_pkg::ST_NEXT;
        else state_next = bmm_pkg::ST_TF_RD;
      end
      bmm_pkg::ST_DFS: begin
        if (cur_p >= deg[cur_v]) state_next = (depth == '0) ? bmm_pkg::ST_NEXT : bmm_pkg::ST_DFS;
        else state_next = bmm_pkg::ST_DFS_CHK;
      end
      bmm_pkg::ST_DFS_CHK: begin
        if (rp_ok[u] && !visited[w]) state_next = bmm_pkg::ST_TF_RD;
        else state_next = bmm_pkg::ST_DFS;
      end
      bmm_pkg::ST_AUG_RD: state_next = (d == '0) ? bmm_pkg::ST_NEXT : bmm_pkg::ST_AUG_WR;
      bmm_pkg::ST_AUG_WR: state_next = bmm_pkg::ST_AUG_RD;
      bmm_pkg::ST_EMIT:   if (emit_go && (j == n - 1'b1)) state_next = bmm_pkg::ST_CLEAR;
      bmm_pkg::ST_CLEAR:  state_next = bmm_pkg::ST_IDLE;
      default:            state_next = bmm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= bmm_pkg::ST_IDLE;
    else state <= state_next;
  end

  // datapath and store updates
  always_ff @(posedge clk) begin
    if (rst) begin
      left_count  <= CW'(16);
      right_count <= CW'(16);
      for (int k = 0; k < bmm_pkg::LEFT_MAX; k++) begin
        deg[k] <= '0; lp_ok[k] <= 1'b0; visited[k] <= 1'b0;
      end
      for (int k = 0; k < bmm_pkg::RIGHT_MAX; k++) rp_ok[k] <= 1'b0;
      running <= '0;
      drop <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bmm_pkg::REG_LEFT_COUNT:  left_count  <= cfg_data;
          bmm_pkg::REG_RIGHT_COUNT: right_count <= cfg_data;
          default: ;
        endcase
      end
      // result beat held until taken, a new one loaded in the same cycle
      if (state == bmm_pkg::ST_EMIT && emit_go) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        bmm_pkg::ST_IDLE: begin
          if (in_acc && has_edge) begin
            if (edge_bad) drop <= 1'b1;
            else deg[left_vertex] <= deg[left_vertex] + 1'b1;
          end
        end
        bmm_pkg::ST_ROUND: begin
          for (int k = 0; k < bmm_pkg::LEFT_MAX; k++) visited[k] <= 1'b0;
          cnt <= '0;
          i <= '0;
        end
        bmm_pkg::ST_NEXT: begin
          if (i >= n) begin
            running <= running + cnt;
            j <= '0;
          end else if (lp_ok[i[VW-1:0]]) begin
            i <= i + 1'b1;
          end else begin
            tf_v <= i[VW-1:0];
            tf_k <= '0;
            tf_ret <= 1'b0;
            visited[i[VW-1:0]] <= 1'b1;
          end
        end
        bmm_pkg::ST_TF_RD: begin
          if (tf_k >= deg[tf_v]) begin
            if (!tf_ret) begin
              depth <= '0;
              sv[0] <= tf_v;
              sp[0] <= '0;
            end else if (depth != '1) begin
              depth <= depth + 1'b1;
              sv[depth + 1'b1] <= tf_v;
              sp[depth + 1'b1] <= '0;
            end else begin
              sp[depth] <= sp[depth] + 1'b1;
            end
          end
        end
        bmm_pkg::ST_TF_CHK: begin
          if (!rp_ok[u]) begin
            rp_ok[u] <= 1'b1;
            rp[u] <= tf_v;
            lp_ok[tf_v] <= 1'b1;
            lp[tf_v] <= u;
            d <= {1'b0, depth} + 1'b1;
          end else begin
            tf_k <= tf_k + 1'b1;
          end
        end
        bmm_pkg::ST_DFS: begin
          if (cur_p >= deg[cur_v]) begin
            if (depth == '0) i <= i + 1'b1;
            else begin
              depth <= depth - 1'b1;
              sp[depth - 1'b1] <= sp[depth - 1'b1] + 1'b1;
            end
          end
        end
        bmm_pkg::ST_DFS_CHK: begin
          if (rp_ok[u] && !visited[w]) begin
            visited[w] <= 1'b1;
            tf_v <= w;
            tf_k <= '0;
            tf_ret <= 1'b1;
          end else begin
            sp[depth] <= sp[depth] + 1'b1;
          end
        end
        bmm_pkg::ST_AUG_RD: begin
          if (d == '0) begin
            cnt <= cnt + 1'b1;
            i <= i + 1'b1;
          end
        end
        bmm_pkg::ST_AUG_WR: begin
          // flip the edge taken at this stack level
          lp[sv[dm1]] <= u;
          lp_ok[sv[dm1]] <= 1'b1;
          rp[u] <= sv[dm1];
          rp_ok[u] <= 1'b1;
          d <= d - 1'b1;
        end
        bmm_pkg::ST_EMIT: begin
          if (emit_go) begin
            vertex_index  <= j[VW-1:0];
            is_matched    <= lp_ok[j[VW-1:0]];
            partner       <= lp_ok[j[VW-1:0]] ? lp[j[VW-1:0]] : '0;
            match_count   <= running;
            dropped_edges <= drop;
            last_result   <= (j == n - 1'b1);
            j <= j + 1'b1;
          end
        end
        bmm_pkg::ST_CLEAR: begin
          for (int k = 0; k < bmm_pkg::LEFT_MAX; k++) begin
            deg[k] <= '0; lp_ok[k] <= 1'b0; visited[k] <= 1'b0;
          end
          for (int k = 0; k < bmm_pkg::RIGHT_MAX; k++) rp_ok[k] <= 1'b0;
          running <= '0;
          drop <= 1'b0;
        end
        default: ;
      endcase
      // root take_free success counts directly
      if (state == bmm_pkg::ST_TF_CHK && !rp_ok[u] && !tf_ret) begin
        cnt <= cnt + 1'b1;
        i <= i + 1'b1;
      end
    end
  end
endmodule

@@ verif/tb_bipartite_max_matching.sv @@
`timescale 1ns / 1ps
// expected result row for one left vertex after a solve
typedef struct {
  logic [3:0] vtx;
  logic       matched;
  logic [3:0] mate;
  logic [4:0] size;
  logic       dropped;
  logic       tail;
} match_row_t;

class matching_scoreboard;
  logic [3:0] adj [16][8];
  int         deg [16];
  int         lmate [16];
  int         rmate [16];
  bit         seen [16];
  int         path_v [16];
  int         path_p [16];
  int         total;
  bit         dropped;
  logic [4:0] left_reg;
  logic [4:0] right_reg;
  match_row_t rows [$];

  function new();
    left_reg  = 5'd16;
    right_reg = 5'd16;
    wipe();
  endfunction

  function void wipe();
    for (int i = 0; i < 16; i++) begin
      deg[i] = 0;
      lmate[i] = -1;
      rmate[i] = -1;
      seen[i] = 0;
    end
    total = 0;
    dropped = 0;
  endfunction

  function int eff_count(logic [4:0] v);
    if (v == 0) return 1;
    if (v > 16) return 16;
    return int'(v);
  endfunction

  // visit v and grab its first free neighbor in list order
  function bit take_free(int v);
    int u;
    seen[v] = 1;
    for (int k = 0; k < deg[v]; k++) begin
      u = adj[v][k];
      if (rmate[u] < 0) begin
        rmate[u] = v;
        lmate[v] = u;
        return 1;
      end
    end
    return 0;
  endfunction

  // depth-first displacement search on an explicit path stack
  function bit augment(int root);
    int depth, v, p, u, w, x, y;
    depth = 0;
    if (take_free(root)) return 1;
    path_v[0] = root;
    path_p[0] = 0;
    forever begin
      v = path_v[depth];
      p = path_p[depth];
      if (p >= deg[v]) begin
        if (depth == 0) return 0;
        depth--;
        path_p[depth]++;
        continue;
      end
      u = adj[v][p];
      w = rmate[u];
      if (w >= 0 && !seen[w]) begin
        if (take_free(w)) begin
          for (int d = depth; d >= 0; d--) begin
            x = path_v[d];
            y = adj[x][path_p[d]];
            lmate[x] = y;
            rmate[y] = x;
          end
          return 1;
        end
        if (depth + 1 < 16) begin
          depth++;
          path_v[depth] = w;
          path_p[depth] = 0;
          continue;
        end
      end
      path_p[depth]++;
    end
  endfunction

  function void note_beat(logic [3:0] lv, logic [3:0] rv, logic he, logic le);
    int n, m, added;
    match_row_t r;
    n = eff_count(left_reg);
    m = eff_count(right_reg);
    if (he) begin
      if (lv >= n || rv >= m || deg[lv] >= 8) dropped = 1;
      else begin
        adj[lv][deg[lv]] = rv;
        deg[lv]++;
      end
    end
    if (!le) return;
    do begin
      for (int i = 0; i < 16; i++) seen[i] = 0;
      added = 0;
      for (int i = 0; i < n; i++)
        if (lmate[i] < 0 && augment(i)) added++;
      total += added;
    end while (added != 0);
    for (int i = 0; i < n; i++) begin
      r.vtx     = 4'(i);
      r.matched = lmate[i] >= 0;
      r.mate    = r.matched ? 4'(lmate[i]) : 4'd0;
      r.size    = total > 31 ? 5'd31 : 5'(total);
      r.dropped = dropped;
      r.tail    = (i == n - 1);
      rows = {rows, r};
    end
    wipe();
  endfunction

  function int check_row(match_row_t got);
    match_row_t want;
    int bad;
    bad = 0;
    if (rows.size() == 0) begin
      $display("%0t: unexpected result beat vertex %0d", $time, got.vtx);
      return 1;
    end
    want = rows.pop_front();
    if (got.vtx !== want.vtx) begin
      $display("%0t: vertex_index exp %0d got %0d", $time, want.vtx, got.vtx);
      bad++;
    end
    if (got.matched !== want.matched) begin
      $display("%0t: is_matched exp %0d got %0d", $time, want.matched, got.matched);
      bad++;
    end
    if (got.mate !== want.mate) begin
      $display("%0t: partner exp %0d got %0d", $time, want.mate, got.mate);
      bad++;
    end
    if (got.size !== want.size) begin
      $display("%0t: match_count exp %0d got %0d", $time, want.size, got.size);
      bad++;
    end
    if (got.dropped !== want.dropped) begin
      $display("%0t: dropped_edges exp %0d got %0d", $time, want.dropped, got.dropped);
      bad++;
    end
    if (got.tail !== want.tail) begin
      $display("%0t: last_result exp %0d got %0d", $time, want.tail, got.tail);
      bad++;
    end
    return bad;
  endfunction
endclass

module tb_bipartite_max_matching;
  localparam int CYCLE_LIMIT = 5000000;

  logic       clk = 0;
  logic       rst = 1;
  logic       cfg_we = 0;
  logic [0:0] cfg_index = bmm_pkg::REG_LEFT_COUNT;
  logic [4:0] cfg_data = '0;
  logic       in_valid = 0;
  logic       in_stall;
  logic [3:0] left_vertex = '0;
  logic [3:0] right_vertex = '0;
  logic       has_edge = 0;
  logic       last_edge = 0;
  logic       out_valid;
  logic       out_stall = 0;
  logic [3:0] vertex_index;
  logic       is_matched;
  logic [3:0] partner;
  logic [4:0] match_count;
  logic       dropped_edges;
  logic       last_result;

  matching_scoreboard sb = new();
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int sent = 0;

  bipartite_max_matching dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver side: random stall, changed at the falling edge
  always @(negedge clk)
    out_stall <= !rst && ($urandom_range(0, 99) < recv_stall_pct);

  // result beats are taken at the rising edge
  always @(posedge clk) begin
    match_row_t got;
    if (!rst && out_valid && !out_stall) begin
      got.vtx = vertex_index;
      got.matched = is_matched;
      got.mate = partner;
      got.size = match_count;
      got.dropped = dropped_edges;
      got.tail = last_result;
      errors += sb.check_row(got);
    end
  end

  // one edge beat; idles first at random, holds until accepted
  task automatic send_beat(logic [3:0] lv, logic [3:0] rv, logic he, logic le);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    left_vertex = lv;
    right_vertex = rv;
    has_edge = he;
    last_edge = le;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    sb.note_beat(lv, rv, he, le);
    sent++;
    @(negedge clk);
    in_valid = 0;
  endtask

  // wait for every outstanding result, then let the clear pass finish
  task automatic drain();
    while (sb.rows.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  // register write, only issued while the block is idle
  task automatic write_reg(logic [0:0] idx, logic [4:0] val);
    drain();
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    if (idx == bmm_pkg::REG_LEFT_COUNT) sb.left_reg = val;
    else sb.right_reg = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  function automatic logic [4:0] pick_count();
    case ($urandom_range(0, 6))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd16;
      3: return 5'd31;
      4: return 5'($urandom_range(17, 30));
      default: return 5'($urandom_range(2, 16));
    endcase
  endfunction

  // one random graph: mostly in-range edges, a little noise, then the last beat
  task automatic random_graph();
    int n, m, len, kind;
    n = sb.eff_count(sb.left_reg);
    m = sb.eff_count(sb.right_reg);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 14);
    for (int i = 0; i < len; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 85)
        send_beat(4'($urandom_range(0, n - 1)), 4'($urandom_range(0, m - 1)), 1, 0);
      else if (kind < 95)
        send_beat(4'($urandom), 4'($urandom), 1, 0);
      else
        send_beat(4'($urandom), 4'($urandom), 0, 0);
    end
    send_beat(4'($urandom_range(0, n - 1)), 4'($urandom_range(0, m - 1)),
              1'($urandom), 1);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // full-size graph: corner vertices, a marker-only beat, edge riding on last
    send_beat(4'd0, 4'd0, 1, 0);
    send_beat(4'd15, 4'd15, 1, 0);
    send_beat(4'd0, 4'd15, 1, 0);
    send_beat(4'd3, 4'd5, 0, 0);
    send_beat(4'd15, 4'd0, 1, 1);

    // degree overflow on one vertex, bare last beat
    for (int i = 0; i < 9; i++) send_beat(4'd1, 4'(i), 1, 0);
    send_beat(4'd2, 4'd0, 0, 1);

    // out-of-range edges, then left set shrunk after loading
    write_reg(bmm_pkg::REG_LEFT_COUNT, 5'd4);
    write_reg(bmm_pkg::REG_RIGHT_COUNT, 5'd3);
    send_beat(4'd5, 4'd1, 1, 0);
    send_beat(4'd1, 4'd7, 1, 0);
    send_beat(4'd2, 4'd2, 1, 0);
    send_beat(4'd3, 4'd1, 1, 0);
    write_reg(bmm_pkg::REG_LEFT_COUNT, 5'd2);
    send_beat(4'd0, 4'd0, 0, 1);

    // zero acts as one, oversize acts as the maximum
    write_reg(bmm_pkg::REG_LEFT_COUNT, 5'd0);
    write_reg(bmm_pkg::REG_RIGHT_COUNT, 5'd31);
    send_beat(4'd0, 4'd9, 1, 0);
    send_beat(4'd1, 4'd0, 1, 0);
    send_beat(4'd0, 4'd15, 1, 1);
    write_reg(bmm_pkg::REG_LEFT_COUNT, 5'd16);
    write_reg(bmm_pkg::REG_RIGHT_COUNT, 5'd16);

    // random graphs in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 67 : 0;
      recv_stall_pct = (ph == 0) ? 67 : (ph == 1) ? 6 : 0;
      sent = 0;
      while (sent < 100) begin
        if ($urandom_range(0, 3) == 0) begin
          write_reg(bmm_pkg::REG_LEFT_COUNT, pick_count());
          write_reg(bmm_pkg::REG_RIGHT_COUNT, pick_count());
        end
        // hold off once per phase until the block has emptied
        if (sent == 0) drain();
        random_graph();
      end
    end

    // tail: let the last results come out
    while (sb.rows.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule

@@ sim.f @@
sv/bmm_pkg.sv
sv/bmm_ram.sv
sv/bipartite_max_matching.sv
verif/tb_bipartite_max_matching.sv
